### design/hbcs_pkg.sv
// Shared types, addresses, constants and functions of the bridge configuration space.
package hbcs_pkg;

  localparam int unsigned BANK_COUNT = 3;   // banks filled by the greedy split (1..3)
  localparam int unsigned BANK_SLOTS = 3;   // bank code bytes in the map
  localparam int unsigned SIZE_STEPS = 7;   // bank sizes 8 MB .. 512 MB
  localparam int unsigned CFG_DEPTH  = 256;
  localparam int unsigned ADDR_W     = 8;
  localparam int unsigned MEMSZ_W    = 12;

  localparam logic [MEMSZ_W-1:0] MEMSZ_RESET = 12'd64;

  // Register addresses with special write rules
  localparam logic [7:0] ADDR_CMD_LO   = 8'h04;
  localparam logic [7:0] ADDR_CMD_HI   = 8'h05;
  localparam logic [7:0] ADDR_STAT_HI  = 8'h07;
  localparam logic [7:0] ADDR_APER_LO  = 8'h12;
  localparam logic [7:0] ADDR_APER_HI  = 8'h13;
  localparam logic [7:0] ADDR_BANK0    = 8'h60;
  localparam logic [7:0] ADDR_BANK1    = 8'h61;
  localparam logic [7:0] ADDR_BANK2    = 8'h62;
  localparam logic [7:0] ADDR_BANK_PRS = 8'h63;
  localparam logic [7:0] ADDR_SMRAM    = 8'h6a;
  localparam logic [7:0] ADDR_SHR_LO   = 8'h70;
  localparam logic [7:0] ADDR_SHR_HI   = 8'h71;
  localparam logic [7:0] ADDR_SHW_LO   = 8'h72;
  localparam logic [7:0] ADDR_SHW_HI   = 8'h73;
  localparam logic [7:0] ADDR_GART0    = 8'h91;
  localparam logic [7:0] ADDR_GART1    = 8'h92;
  localparam logic [7:0] ADDR_GART2    = 8'h93;
  localparam logic [7:0] ADDR_APER_CTL = 8'h94;

  // Write masks
  localparam logic [7:0] CMD_LO_KEEP   = 8'hfd;
  localparam logic [7:0] CMD_LO_WR     = 8'h02;
  localparam logic [7:0] CMD_HI_WR     = 8'h03;
  localparam logic [7:0] STAT_W1C      = 8'h70;
  localparam logic [7:0] STAT_SET      = 8'h01;
  localparam logic [7:0] APER_LO_WR    = 8'hc0;
  localparam logic [7:0] APER_CTL_WR   = 8'h7f;
  localparam logic [7:0] BANK_CODE_SET = 8'hc0;
  localparam logic [31:0] APER_BASE_KEEP = 32'hf000_0000;
  localparam logic [31:0] APER_MIN_SIZE  = 32'h0040_0000;
  localparam logic [2:0]  APER_CODE_OFF  = 3'd7;

  // SMRAM window constants
  localparam logic [19:0] SMRAM_SEG_E = 20'he_0000;
  localparam logic [19:0] SMRAM_SEG_A = 20'ha_0000;
  localparam logic [19:0] SMRAM_SEG_B = 20'hb_0000;
  localparam logic [16:0] SMRAM_SZ_32K = 17'h0_8000;
  localparam logic [16:0] SMRAM_SZ_64K = 17'h1_0000;

  // Bank codes for 8, 16, 32, 64, 128, 256, 512 MB
  localparam logic [7:0] DRAM_SIZE_CODE [SIZE_STEPS] =
    '{8'h00, 8'h20, 8'h24, 8'h22, 8'h26, 8'h2a, 8'h2b};

  // Bytes kept in flops: they feed the decoded levels
  typedef struct packed {
    logic [7:0] b6a;
    logic [7:0] b70;
    logic [7:0] b71;
    logic [7:0] b72;
    logic [7:0] b73;
    logic [7:0] b12;
    logic [7:0] b13;
    logic [7:0] b91;
    logic [7:0] b92;
    logic [7:0] b93;
    logic [7:0] b94;
  } mirror_t;

  typedef struct packed {
    logic [BANK_SLOTS-1:0][7:0] code;
    logic [BANK_SLOTS-1:0]      present;
  } bank_info_t;

  function automatic logic [31:0] aper_size(input logic [2:0] code);
    logic [31:0] size;
    if (code == APER_CODE_OFF) begin
      size = '0;
    end else begin
      size = APER_MIN_SIZE << code;
    end
    return size;
  endfunction

  function automatic logic [7:0] reset_byte(input logic [7:0] a);
    logic [7:0] v;
    case (a)
      8'h00: v = 8'h39;
      8'h01: v = 8'h10;
      8'h03: v = 8'h56;
      8'h04: v = 8'h05;
      8'h06: v = 8'h10;
      8'h07: v = 8'h02;
      8'h08: v = 8'h10;
      8'h0b: v = 8'h06;
      8'h0d: v = 8'hff;
      8'h0e: v = 8'h80;
      8'h34: v = 8'hc0;
      8'h50: v = 8'h02;
      8'h51: v = 8'h02;
      8'h63: v = 8'hff;
      8'h84: v = 8'hff;
      8'h85: v = 8'hff;
      8'h86: v = 8'hff;
      8'h8d: v = 8'h62;
      8'hc0: v = 8'h02;
      8'hc2: v = 8'h10;
      8'hc4: v = 8'h03;
      8'hc5: v = 8'h02;
      8'hc7: v = 8'h1f;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // Bytes that take the written value as is (SMRAM and shadow-map mirrors included)
  function automatic logic is_plain(input logic [7:0] a);
    return a inside {8'h0d, [8'h50:8'h5a], [8'h64:8'h6c], [8'h70:8'h75],
                     [8'h77:8'h80], [8'h82:8'h8f], [8'h97:8'h9b], [8'hc8:8'hcb],
                     [8'hd4:8'hd8], 8'hda, 8'he0, [8'he2:8'he3]};
  endfunction

  function automatic logic is_mirror(input logic [7:0] a);
    return a inside {ADDR_SMRAM, ADDR_SHR_LO, ADDR_SHR_HI, ADDR_SHW_LO, ADDR_SHW_HI,
                     ADDR_APER_LO, ADDR_APER_HI, ADDR_GART0, ADDR_GART1, ADDR_GART2,
                     ADDR_APER_CTL};
  endfunction

endpackage

### design/hbcs_ram.sv
// Generic single-clock RAM: one write port, one read port with registered read data.
module hbcs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/hbcs_bank.sv
// Memory-size register and greedy split of installed memory into bank codes.
module hbcs_bank (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [hbcs_pkg::MEMSZ_W-1:0]  cfg_data_i,
  output logic                          cfg_ready_o,
  output hbcs_pkg::bank_info_t          bank_o
);

  logic [hbcs_pkg::MEMSZ_W-1:0] memsz_q;

  // Take the largest size that fits, bank by bank
  function automatic hbcs_pkg::bank_info_t split(input logic [hbcs_pkg::MEMSZ_W-1:0] mb);
    hbcs_pkg::bank_info_t info;
    logic [hbcs_pkg::MEMSZ_W-1:0] left;
    logic [hbcs_pkg::MEMSZ_W-1:0] sz;
    logic found;
    info = '0;
    left = mb;
    for (int b = 0; b < hbcs_pkg::BANK_SLOTS; b++) begin
      found = 1'b0;
      if (b < hbcs_pkg::BANK_COUNT) begin
        for (int j = hbcs_pkg::SIZE_STEPS - 1; j >= 0; j--) begin
          sz = hbcs_pkg::MEMSZ_W'(8) << j;
          if (!found && sz <= left) begin
            info.code[b]    = hbcs_pkg::DRAM_SIZE_CODE[j];
            info.present[b] = 1'b1;
            found           = 1'b1;
          end
        end
        for (int j = hbcs_pkg::SIZE_STEPS - 1; j >= 0; j--) begin
          if (info.code[b] == hbcs_pkg::DRAM_SIZE_CODE[j] && info.present[b]) begin
            left = left - (hbcs_pkg::MEMSZ_W'(8) << j);
          end
        end
      end
    end
    return info;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      memsz_q <= hbcs_pkg::MEMSZ_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      memsz_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign bank_o      = split(memsz_q);

endmodule

### design/hbcs_decode.sv
// Decode of shadow maps, SMRAM window and aperture/GART levels from mirrored bytes.
module hbcs_decode (
  input  hbcs_pkg::mirror_t mirror_i,
  output logic [12:0]       shadow_read_map_o,
  output logic [12:0]       shadow_write_map_o,
  output logic [19:0]       smram_host_base_o,
  output logic [19:0]       smram_ram_base_o,
  output logic [16:0]       smram_size_o,
  output logic              smram_flag_o,
  output logic [31:0]       aperture_base_o,
  output logic [28:0]       aperture_size_o,
  output logic              aperture_enable_o,
  output logic [31:0]       gart_base_o
);

  logic [1:0]  mode;
  logic [31:0] size;

  assign mode = mirror_i.b6a[7:6];
  assign size = hbcs_pkg::aper_size(mirror_i.b94[6:4]);

  assign shadow_read_map_o  = {mirror_i.b71[4:0], mirror_i.b70};
  assign shadow_write_map_o = {mirror_i.b73[4:0], mirror_i.b72};

  assign smram_host_base_o = (mode == 2'd3) ? hbcs_pkg::SMRAM_SEG_A : hbcs_pkg::SMRAM_SEG_E;
  assign smram_size_o      = (mode == 2'd3) ? hbcs_pkg::SMRAM_SZ_64K : hbcs_pkg::SMRAM_SZ_32K;
  assign smram_flag_o      = mirror_i.b6a[4];

  always_comb begin
    case (mode)
      2'd0:    smram_ram_base_o = hbcs_pkg::SMRAM_SEG_E;
      2'd2:    smram_ram_base_o = hbcs_pkg::SMRAM_SEG_B;
      default: smram_ram_base_o = hbcs_pkg::SMRAM_SEG_A;
    endcase
  end

  assign aperture_base_o   = {mirror_i.b13, mirror_i.b12, 16'h0000};
  assign aperture_size_o   = size[28:0];
  assign aperture_enable_o = mirror_i.b94[1];
  assign gart_base_o       = mirror_i.b94[0] ?
                             {mirror_i.b93, mirror_i.b92, mirror_i.b91, 8'h00} : 32'h0;

endmodule

### design/host_bridge_config_space.sv
// Top level of the host bridge configuration space: access control, RAM and byte rules.
//
// Each access (start_i high while busy_o is low) presents its address to the
// byte RAM as it is taken; the RAM's registered output gives the old byte in
// the next cycle, the write-back cycle, in which busy_o is high and the byte
// is written back modified. The result word follows on the outputs for one
// cycle, marked by done_o; the receiver cannot stall it, and a new access may
// be started in that same cycle, though not during a write-back. The RAM has
// one valid bit per byte that reset clears, so an unwritten byte reads as its
// reset value and no clearing pass runs after reset. The bytes that feed the
// decoded levels (SMRAM control, shadow maps, aperture base and control, GART
// base) live in flops and are read from there. The memory-size register is
// written through cfg_valid_i/cfg_ready_o, by the user only while idle (the
// block does not enforce it); bank bytes pick up the split on their next write.
module host_bridge_config_space (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // access channel
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         req_type_i,
  input  logic [7:0]                   reg_addr_i,
  input  logic [7:0]                   write_data_i,
  // result channel
  output logic                         done_o,
  output logic [7:0]                   read_data_o,
  output logic [12:0]                  shadow_read_map_o,
  output logic [12:0]                  shadow_write_map_o,
  output logic [19:0]                  smram_host_base_o,
  output logic [19:0]                  smram_ram_base_o,
  output logic [16:0]                  smram_size_o,
  output logic                         smram_flag_o,
  output logic [31:0]                  aperture_base_o,
  output logic [28:0]                  aperture_size_o,
  output logic                         aperture_enable_o,
  output logic [31:0]                  gart_base_o,
  // memory-size register
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [hbcs_pkg::MEMSZ_W-1:0] cfg_data_i
);

  logic                               accept;
  logic                               busy_q;
  logic                               done_q;
  logic                               wr_q;
  logic [hbcs_pkg::ADDR_W-1:0]        addr_q;
  logic [7:0]                         wdata_q;
  logic [7:0]                         read_data_q;
  logic [7:0]                         read_data_d;
  logic [hbcs_pkg::CFG_DEPTH-1:0]     valid_q;
  logic [7:0]                         ram_rdata;
  logic [7:0]                         old_byte;
  logic [7:0]                         mirror_byte;
  logic                               ram_we;
  logic [7:0]                         ram_wdata;
  logic                               ram_writable;
  hbcs_pkg::mirror_t                  mirror_q;
  hbcs_pkg::mirror_t                  mirror_d;
  hbcs_pkg::bank_info_t               bank;
  logic [31:0]                        aper_mask;
  logic [15:0]                        aper_bar;
  logic                               remask;

  assign accept = start_i && !busy_q;
  assign busy_o = busy_q;
  assign done_o = done_q;

  hbcs_bank u_bank (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .bank_o      (bank)
  );

  // Read the old byte as the access is taken; write back in the next cycle
  hbcs_ram #(
    .WIDTH (8),
    .DEPTH (hbcs_pkg::CFG_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (ram_wdata),
    .raddr_i (reg_addr_i),
    .rdata_o (ram_rdata)
  );

  // Unwritten bytes read as their reset value
  assign old_byte = valid_q[addr_q] ? ram_rdata : hbcs_pkg::reset_byte(addr_q);

  always_comb begin
    case (addr_q)
      hbcs_pkg::ADDR_SMRAM:    mirror_byte = mirror_q.b6a;
      hbcs_pkg::ADDR_SHR_LO:   mirror_byte = mirror_q.b70;
      hbcs_pkg::ADDR_SHR_HI:   mirror_byte = mirror_q.b71;
      hbcs_pkg::ADDR_SHW_LO:   mirror_byte = mirror_q.b72;
      hbcs_pkg::ADDR_SHW_HI:   mirror_byte = mirror_q.b73;
      hbcs_pkg::ADDR_APER_LO:  mirror_byte = mirror_q.b12;
      hbcs_pkg::ADDR_APER_HI:  mirror_byte = mirror_q.b13;
      hbcs_pkg::ADDR_GART0:    mirror_byte = mirror_q.b91;
      hbcs_pkg::ADDR_GART1:    mirror_byte = mirror_q.b92;
      hbcs_pkg::ADDR_GART2:    mirror_byte = mirror_q.b93;
      hbcs_pkg::ADDR_APER_CTL: mirror_byte = mirror_q.b94;
      default:                 mirror_byte = old_byte;
    endcase
  end

  // Write rules for bytes kept in RAM
  always_comb begin
    ram_writable = 1'b1;
    case (addr_q)
      hbcs_pkg::ADDR_CMD_LO:
        ram_wdata = (old_byte & hbcs_pkg::CMD_LO_KEEP) | (wdata_q & hbcs_pkg::CMD_LO_WR);
      hbcs_pkg::ADDR_CMD_HI:
        ram_wdata = wdata_q & hbcs_pkg::CMD_HI_WR;
      hbcs_pkg::ADDR_STAT_HI:
        ram_wdata = (old_byte & ~(wdata_q & hbcs_pkg::STAT_W1C)) |
                    (wdata_q & hbcs_pkg::STAT_SET);
      hbcs_pkg::ADDR_BANK0:    ram_wdata = bank.code[0] | hbcs_pkg::BANK_CODE_SET;
      hbcs_pkg::ADDR_BANK1:    ram_wdata = bank.code[1] | hbcs_pkg::BANK_CODE_SET;
      hbcs_pkg::ADDR_BANK2:    ram_wdata = bank.code[2] | hbcs_pkg::BANK_CODE_SET;
      hbcs_pkg::ADDR_BANK_PRS: ram_wdata = {{(8 - hbcs_pkg::BANK_SLOTS){1'b0}}, bank.present};
      default: begin
        ram_wdata    = wdata_q;
        ram_writable = hbcs_pkg::is_plain(addr_q);
      end
    endcase
  end

  assign ram_we = busy_q && wr_q && ram_writable && !hbcs_pkg::is_mirror(addr_q);

  // Write rules for mirrored bytes, then re-mask the aperture base
  always_comb begin
    mirror_d = mirror_q;
    remask   = 1'b0;
    if (busy_q && wr_q) begin
      case (addr_q)
        hbcs_pkg::ADDR_SMRAM:  mirror_d.b6a = wdata_q;
        hbcs_pkg::ADDR_SHR_LO: mirror_d.b70 = wdata_q;
        hbcs_pkg::ADDR_SHR_HI: mirror_d.b71 = wdata_q;
        hbcs_pkg::ADDR_SHW_LO: mirror_d.b72 = wdata_q;
        hbcs_pkg::ADDR_SHW_HI: mirror_d.b73 = wdata_q;
        hbcs_pkg::ADDR_APER_LO: begin
          mirror_d.b12 = wdata_q & hbcs_pkg::APER_LO_WR;
          remask       = 1'b1;
        end
        hbcs_pkg::ADDR_APER_HI: begin
          mirror_d.b13 = wdata_q;
          remask       = 1'b1;
        end
        hbcs_pkg::ADDR_GART0: begin
          mirror_d.b91 = wdata_q;
          remask       = 1'b1;
        end
        hbcs_pkg::ADDR_GART1: begin
          mirror_d.b92 = wdata_q;
          remask       = 1'b1;
        end
        hbcs_pkg::ADDR_GART2: begin
          mirror_d.b93 = wdata_q;
          remask       = 1'b1;
        end
        hbcs_pkg::ADDR_APER_CTL: begin
          mirror_d.b94 = wdata_q & hbcs_pkg::APER_CTL_WR;
          remask       = 1'b1;
        end
        default: ;
      endcase
    end
    aper_mask = hbcs_pkg::aper_size(mirror_d.b94[6:4]) | hbcs_pkg::APER_BASE_KEEP;
    aper_bar  = {mirror_d.b13, mirror_d.b12} & aper_mask[31:16];
    if (remask) begin
      mirror_d.b13 = aper_bar[15:8];
      mirror_d.b12 = aper_bar[7:0];
    end
  end

  assign read_data_d = wr_q ? 8'h00 : mirror_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      valid_q  <= '0;
      mirror_q <= '0;
    end else begin
      busy_q   <= accept;
      done_q   <= busy_q;
      mirror_q <= mirror_d;
      if (ram_we) begin
        valid_q[addr_q] <= 1'b1;
      end
    end
  end

  // Hold the access and the read byte; no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      wr_q    <= req_type_i;
      addr_q  <= reg_addr_i;
      wdata_q <= write_data_i;
    end
    if (busy_q) begin
      read_data_q <= read_data_d;
    end
  end

  assign read_data_o = read_data_q;

  hbcs_decode u_decode (
    .mirror_i           (mirror_q),
    .shadow_read_map_o  (shadow_read_map_o),
    .shadow_write_map_o (shadow_write_map_o),
    .smram_host_base_o  (smram_host_base_o),
    .smram_ram_base_o   (smram_ram_base_o),
    .smram_size_o       (smram_size_o),
    .smram_flag_o       (smram_flag_o),
    .aperture_base_o    (aperture_base_o),
    .aperture_size_o    (aperture_size_o),
    .aperture_enable_o  (aperture_enable_o),
    .gart_base_o        (gart_base_o)
  );

  // The write-back cycle never runs twice in a row
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q |=> !busy_q)
    else $error("write-back cycle repeated");

  // Every write-back cycle yields exactly one result word
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q |=> done_q)
    else $error("result missing after write-back");

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> $past(busy_q))
    else $error("result without an access");

  // Write results carry a zero read byte
  assert property (@(posedge clk_i) disable iff (!rst_ni) (done_q && wr_q) |-> read_data_q == 8'h00)
    else $error("nonzero read byte on a write");

  // Low aperture base bits are never writable
  assert property (@(posedge clk_i) disable iff (!rst_ni) mirror_q.b12[5:0] == 6'd0)
    else $error("aperture base low bits set");

endmodule

### dv/tb.sv
// Testbench for the host bridge configuration space: random accesses checked against a byte-level mirror.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hbcs_pkg::*;

  // Watchdog limit: cycles in a row with no access, no result and no register write.
  // The slowest correct gap is the longest idle burst plus one access,
  // so this leaves a wide margin.
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned PHASE_ITEMS = 255;
  localparam int unsigned DRAIN_CYCLES = 4;

  // SMRAM window bases and lengths, full 20-bit addresses
  localparam logic [19:0] SEG_E_BASE = 20'he0000;
  localparam logic [19:0] SEG_A_BASE = 20'ha0000;
  localparam logic [19:0] SEG_B_BASE = 20'hb0000;
  localparam logic [16:0] WIN_32K    = 17'h08000;
  localparam logic [16:0] WIN_64K    = 17'h10000;

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // Addresses with special rules or decoded outputs: hit them often
  localparam int unsigned HOT_COUNT = 21;
  localparam logic [7:0] HOT_ADDRS [HOT_COUNT] = '{
    ADDR_CMD_LO, ADDR_CMD_HI, ADDR_STAT_HI, ADDR_APER_LO, ADDR_APER_HI,
    ADDR_BANK0, ADDR_BANK1, ADDR_BANK2, ADDR_BANK_PRS, ADDR_SMRAM,
    ADDR_SHR_LO, ADDR_SHR_HI, ADDR_SHW_LO, ADDR_SHW_HI, ADDR_GART0,
    ADDR_GART1, ADDR_GART2, ADDR_APER_CTL, ADDR_APER_CTL, ADDR_SMRAM, 8'h0d
  };

  // One result word of the block
  typedef struct {
    logic [7:0]  read_data;
    logic [12:0] shr_map;
    logic [12:0] shw_map;
    logic [19:0] host_base;
    logic [19:0] ram_base;
    logic [16:0] win_size;
    logic        smm_flag;
    logic [31:0] aper_base;
    logic [28:0] aper_bytes;
    logic        aper_en;
    logic [31:0] gart;
  } access_word_t;

  // Mirror of the 256 configuration bytes; predicts each result word and
  // checks the words that come back in order.
  class config_space_mirror;
    logic [7:0]   cfg_bytes [256];
    logic [11:0]  mem_mb;
    logic [7:0]   bank_code [3];
    logic [2:0]   bank_present;
    access_word_t awaited [$];
    int           errors;
    int           seen;
    int           writes;

    function new();
      foreach (cfg_bytes[i]) cfg_bytes[i] = 8'h00;
      cfg_bytes[8'h00] = 8'h39; cfg_bytes[8'h01] = 8'h10; cfg_bytes[8'h03] = 8'h56;
      cfg_bytes[8'h04] = 8'h05; cfg_bytes[8'h06] = 8'h10; cfg_bytes[8'h07] = 8'h02;
      cfg_bytes[8'h08] = 8'h10; cfg_bytes[8'h0b] = 8'h06; cfg_bytes[8'h0d] = 8'hff;
      cfg_bytes[8'h0e] = 8'h80; cfg_bytes[8'h34] = 8'hc0; cfg_bytes[8'h50] = 8'h02;
      cfg_bytes[8'h51] = 8'h02; cfg_bytes[8'h63] = 8'hff; cfg_bytes[8'h84] = 8'hff;
      cfg_bytes[8'h85] = 8'hff; cfg_bytes[8'h86] = 8'hff; cfg_bytes[8'h8d] = 8'h62;
      cfg_bytes[8'hc0] = 8'h02; cfg_bytes[8'hc2] = 8'h10; cfg_bytes[8'hc4] = 8'h03;
      cfg_bytes[8'hc5] = 8'h02; cfg_bytes[8'hc7] = 8'h1f;
      mem_mb = MEMSZ_RESET;
      errors = 0;
      seen   = 0;
      writes = 0;
    endfunction

    function logic [31:0] aperture_bytes(input logic [2:0] code);
      return (code == APER_CODE_OFF) ? 32'h0 : (32'h0040_0000 << code);
    endfunction

    function logic takes_any_value(input logic [7:0] a);
      return a == 8'h0d || a == 8'hda || a == 8'he0 ||
             (a >= 8'h50 && a <= 8'h5a) || (a >= 8'h64 && a <= 8'h6c) ||
             (a >= 8'h70 && a <= 8'h75) || (a >= 8'h77 && a <= 8'h80) ||
             (a >= 8'h82 && a <= 8'h8f) || (a >= 8'h97 && a <= 8'h9b) ||
             (a >= 8'hc8 && a <= 8'hcb) || (a >= 8'hd4 && a <= 8'hd8) ||
             (a >= 8'he2 && a <= 8'he3);
    endfunction

    // Greedy split of installed memory: each bank takes the largest size that fits.
    function void split_banks();
      logic [11:0] left;
      logic [11:0] sz;
      logic        placed;
      logic [7:0]  size_codes [7];
      size_codes = '{8'h00, 8'h20, 8'h24, 8'h22, 8'h26, 8'h2a, 8'h2b};
      left = mem_mb;
      bank_present = '0;
      for (int b = 0; b < 3; b++) begin
        bank_code[b] = 8'h00;
        placed = 1'b0;
        if (b < BANK_COUNT) begin
          for (int j = 6; j >= 0; j--) begin
            sz = 12'd8 << j;
            if (!placed && sz <= left) begin
              bank_code[b] = size_codes[j];
              bank_present[b] = 1'b1;
              left = left - sz;
              placed = 1'b1;
            end
          end
        end
      end
    endfunction

    function void remask_aperture();
      logic [31:0] bar;
      bar = {cfg_bytes[ADDR_APER_HI], cfg_bytes[ADDR_APER_LO], 16'h0000};
      bar = bar & (aperture_bytes(cfg_bytes[ADDR_APER_CTL][6:4]) | APER_BASE_KEEP);
      cfg_bytes[ADDR_APER_LO] = bar[23:16];
      cfg_bytes[ADDR_APER_HI] = bar[31:24];
    endfunction

    function void apply_write(input logic [7:0] a, input logic [7:0] v);
      if (takes_any_value(a)) begin
        cfg_bytes[a] = v;
      end else begin
        case (a)
          ADDR_CMD_LO: begin
            cfg_bytes[a] = (cfg_bytes[a] & CMD_LO_KEEP) | (v & CMD_LO_WR);
          end
          ADDR_CMD_HI: begin
            cfg_bytes[a] = v & CMD_HI_WR;
          end
          ADDR_STAT_HI: begin
            cfg_bytes[a] = (cfg_bytes[a] & ~(v & STAT_W1C)) | (v & STAT_SET);
          end
          ADDR_APER_LO: begin
            cfg_bytes[a] = v & APER_LO_WR;
            remask_aperture();
          end
          ADDR_APER_HI, ADDR_GART0, ADDR_GART1, ADDR_GART2: begin
            cfg_bytes[a] = v;
            remask_aperture();
          end
          ADDR_APER_CTL: begin
            cfg_bytes[a] = v & APER_CTL_WR;
            remask_aperture();
          end
          ADDR_BANK0, ADDR_BANK1, ADDR_BANK2: begin
            split_banks();
            cfg_bytes[a] = bank_code[int'(a - ADDR_BANK0)] | BANK_CODE_SET;
          end
          ADDR_BANK_PRS: begin
            split_banks();
            cfg_bytes[a] = {5'b0, bank_present};
          end
          default: begin
          end
        endcase
      end
    endfunction

    // Apply one accepted access and queue the word it must produce.
    function void note_access(input logic wr, input logic [7:0] a, input logic [7:0] v);
      access_word_t w;
      logic [1:0]   mode;
      logic [7:0]   ctl;
      w.read_data = 8'h00;
      if (wr == REQ_WRITE) begin
        apply_write(a, v);
        writes++;
      end else begin
        w.read_data = cfg_bytes[a];
      end
      mode = cfg_bytes[ADDR_SMRAM][7:6];
      ctl  = cfg_bytes[ADDR_APER_CTL];
      w.shr_map    = {cfg_bytes[ADDR_SHR_HI][4:0], cfg_bytes[ADDR_SHR_LO]};
      w.shw_map    = {cfg_bytes[ADDR_SHW_HI][4:0], cfg_bytes[ADDR_SHW_LO]};
      w.host_base  = (mode == 2'd3) ? SEG_A_BASE : SEG_E_BASE;
      w.ram_base   = (mode == 2'd0) ? SEG_E_BASE : (mode == 2'd2) ? SEG_B_BASE : SEG_A_BASE;
      w.win_size   = (mode == 2'd3) ? WIN_64K : WIN_32K;
      w.smm_flag   = cfg_bytes[ADDR_SMRAM][4];
      w.aper_base  = {cfg_bytes[ADDR_APER_HI], cfg_bytes[ADDR_APER_LO], 16'h0000};
      w.aper_bytes = aperture_bytes(ctl[6:4]);
      w.aper_en    = ctl[1];
      w.gart       = ctl[0] ? {cfg_bytes[ADDR_GART2], cfg_bytes[ADDR_GART1],
                               cfg_bytes[ADDR_GART0], 8'h00} : 32'h0;
      awaited.push_back(w);
    endfunction

    function void compare_field(input string name, input logic [31:0] exp_v,
                                input logic [31:0] got_v);
      if (got_v !== exp_v) begin
        errors++;
        $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $realtime, name,
                 exp_v, got_v);
      end
    endfunction

    function void check_result(input access_word_t got);
      access_word_t w;
      seen++;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t ns: result word with nothing awaited, read_data 0x%0h", $realtime,
                 got.read_data);
      end else begin
        w = awaited.pop_front();
        compare_field("read_data",        w.read_data,  got.read_data);
        compare_field("shadow_read_map",  w.shr_map,    got.shr_map);
        compare_field("shadow_write_map", w.shw_map,    got.shw_map);
        compare_field("smram_host_base",  w.host_base,  got.host_base);
        compare_field("smram_ram_base",   w.ram_base,   got.ram_base);
        compare_field("smram_size",       w.win_size,   got.win_size);
        compare_field("smram_flag",       w.smm_flag,   got.smm_flag);
        compare_field("aperture_base",    w.aper_base,  got.aper_base);
        compare_field("aperture_size",    w.aper_bytes, got.aper_bytes);
        compare_field("aperture_enable",  w.aper_en,    got.aper_en);
        compare_field("gart_base",        w.gart,       got.gart);
      end
    endfunction
  endclass

  // Clock and block ports; every input is known from time zero
  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               start_i      = 1'b0;
  logic               req_type_i   = REQ_READ;
  logic [7:0]         reg_addr_i   = 8'h00;
  logic [7:0]         write_data_i = 8'h00;
  logic               cfg_valid_i  = 1'b0;
  logic [MEMSZ_W-1:0] cfg_data_i   = '0;
  logic               busy_o;
  logic               done_o;
  logic               cfg_ready_o;
  access_word_t       got_word;

  config_space_mirror mirror;
  int unsigned        issued = 0;
  int unsigned        quiet_cycles = 0;
  int unsigned        sizes_tried = 1;

  always #2 clk_i = ~clk_i;

  host_bridge_config_space dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .req_type_i         (req_type_i),
    .reg_addr_i         (reg_addr_i),
    .write_data_i       (write_data_i),
    .done_o             (done_o),
    .read_data_o        (got_word.read_data),
    .shadow_read_map_o  (got_word.shr_map),
    .shadow_write_map_o (got_word.shw_map),
    .smram_host_base_o  (got_word.host_base),
    .smram_ram_base_o   (got_word.ram_base),
    .smram_size_o       (got_word.win_size),
    .smram_flag_o       (got_word.smm_flag),
    .aperture_base_o    (got_word.aper_base),
    .aperture_size_o    (got_word.aper_bytes),
    .aperture_enable_o  (got_word.aper_en),
    .gart_base_o        (got_word.gart),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i)
  );

  // Monitor: all inputs change by nonblocking assignment at the edge, so the
  // values read here are the ones the block saw at this edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) mirror.check_result(got_word);
      if (start_i && !busy_o) mirror.note_access(req_type_i, reg_addr_i, write_data_i);
      if (cfg_valid_i && cfg_ready_o) mirror.mem_mb = cfg_data_i;
    end
  end

  // Watchdog: count cycles in a row in which nothing moves on any channel
  always @(posedge clk_i) begin
    if (!rst_ni || done_o || (start_i && !busy_o) || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no progress for %0d cycles", $realtime, STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Hold one access word on the inputs until the block takes it
  task automatic send_access(input logic wr, input logic [7:0] a, input logic [7:0] v);
    start_i      <= 1'b1;
    req_type_i   <= wr;
    reg_addr_i   <= a;
    write_data_i <= v;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    issued++;
  endtask

  task automatic idle_for(input int unsigned n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Drop start and wait until every issued access has produced its word
  task automatic wait_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (mirror.seen < issued) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_memory_size(input logic [MEMSZ_W-1:0] mb);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= mb;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sizes_tried++;
  endtask

  // Corner accesses: ignored writes, every masked byte, all SMRAM modes,
  // aperture codes at both ends, GART on/off, bank bytes 0 and 2 and the presence byte.
  task automatic run_directed();
    send_access(REQ_READ,  8'h00,         8'h00);
    send_access(REQ_READ,  8'hff,         8'hff);
    send_access(REQ_WRITE, 8'h00,         8'hff);
    send_access(REQ_READ,  8'h00,         8'h00);
    send_access(REQ_WRITE, ADDR_CMD_LO,   8'hff);
    send_access(REQ_WRITE, ADDR_CMD_LO,   8'h00);
    send_access(REQ_WRITE, ADDR_CMD_HI,   8'hff);
    send_access(REQ_WRITE, ADDR_STAT_HI,  8'hff);
    send_access(REQ_WRITE, ADDR_STAT_HI,  8'h01);
    send_access(REQ_WRITE, ADDR_APER_HI,  8'hff);
    send_access(REQ_WRITE, ADDR_APER_LO,  8'hff);
    send_access(REQ_WRITE, ADDR_APER_CTL, 8'hff);
    send_access(REQ_WRITE, ADDR_APER_CTL, 8'h00);
    send_access(REQ_WRITE, ADDR_GART0,    8'hff);
    send_access(REQ_WRITE, ADDR_GART1,    8'haa);
    send_access(REQ_WRITE, ADDR_GART2,    8'h55);
    send_access(REQ_WRITE, ADDR_APER_CTL, 8'h61);
    send_access(REQ_WRITE, ADDR_SMRAM,    8'hc0);
    send_access(REQ_WRITE, ADDR_SMRAM,    8'h90);
    send_access(REQ_WRITE, ADDR_SMRAM,    8'h40);
    send_access(REQ_WRITE, ADDR_SHR_LO,   8'hff);
    send_access(REQ_WRITE, ADDR_SHR_HI,   8'hff);
    send_access(REQ_WRITE, ADDR_SHW_HI,   8'hff);
    send_access(REQ_WRITE, ADDR_BANK0,    8'h00);
    send_access(REQ_WRITE, ADDR_BANK2,    8'h00);
    send_access(REQ_WRITE, ADDR_BANK_PRS, 8'h00);
  endtask

  // Random accesses, weighted toward the addresses with rules or outputs.
  // Idle bursts come and go in stretches of 40 words; a rare full drain
  // makes the block finish everything before the next word.
  task automatic run_random(input int unsigned n, input bit may_idle);
    logic        wr;
    logic [7:0]  a;
    bit          quiet;
    int unsigned roll;
    quiet = 1'b1;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 40 == 0) quiet = ($urandom_range(0, 2) == 0);
      wr = ($urandom_range(0, 99) < 60) ? REQ_WRITE : REQ_READ;
      if ($urandom_range(0, 99) < 60) begin
        a = HOT_ADDRS[$urandom_range(0, HOT_COUNT - 1)];
      end else begin
        a = 8'($urandom_range(0, 255));
      end
      send_access(wr, a, 8'($urandom_range(0, 255)));
      if (may_idle && !quiet) begin
        roll = $urandom_range(0, 99);
        if (roll < 20) begin
          idle_for($urandom_range(1, 14));
        end else if (roll == 20) begin
          wait_drained();
        end
      end
    end
  endtask

  initial begin
    logic [MEMSZ_W-1:0] sizes [6];
    mirror = new();
    sizes = '{12'd0, 12'd2048, 12'd7, 12'd2047, 12'd960, MEMSZ_W'($urandom_range(0, 2048))};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    run_directed();

    // Advance through the memory sizes; the last phase runs back to back
    foreach (sizes[p]) begin
      wait_drained();
      write_memory_size(sizes[p]);
      run_random(PHASE_ITEMS, p != 5);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mirror.awaited.size() != 0) begin
      mirror.errors++;
      $display("%0t ns: %0d result words never arrived", $realtime, mirror.awaited.size());
    end

    $display("Ran %0d accesses (%0d writes) across %0d memory sizes, checking %0d words.",
             issued, mirror.writes, sizes_tried, mirror.seen);
    $display("Mismatches found: %0d", mirror.errors);
    if (mirror.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
